/* sv/mcfh_pkg.sv */
// Shared types and constants for the multi-color first-hit finder.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package mcfh_pkg;

   localparam int COORD_BITS       = 12;
   localparam int CHAN_BITS        = 8;
   localparam int DIFF_SUM_BITS    = 10;
   localparam int ENTRY_COUNT_BITS = 3;
   localparam int ENTRY_BITS       = 48;
   localparam int CSR_INDEX_BITS   = 3;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DIFF_SUM = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRY_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENTRY0       = 3'd2;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [CHAN_BITS-1:0]  blue;
      logic [CHAN_BITS-1:0]  green;
      logic [CHAN_BITS-1:0]  red;
      logic                  last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic                  found;
      logic [COORD_BITS-1:0] hit_x;
      logic [COORD_BITS-1:0] hit_y;
   } rsp_payload_type;

   // one target color entry, as written through the configuration port
   typedef struct packed {
      logic [CHAN_BITS-1:0] red_shift;
      logic [CHAN_BITS-1:0] green_shift;
      logic [CHAN_BITS-1:0] blue_shift;
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } color_entry_type;

   // classified pixel, as it waits between front and back
   typedef struct packed {
      logic                  hit;
      logic                  last_pixel;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } queue_item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* sv/mcfh_front.sv */
// Front end: configuration registers and the per-entry color match of one pixel.
// Depends on mcfh_pkg.
`default_nettype none

module mcfh_front #(
   parameter int COLOR_ENTRIES = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [mcfh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mcfh_pkg::ENTRY_BITS-1:0]      csr_data,
   input  wire mcfh_pkg::req_payload_type            pixel,
   output mcfh_pkg::queue_item_type                  item
);

   logic [mcfh_pkg::DIFF_SUM_BITS-1:0]    max_diff_sum_ff;
   logic [mcfh_pkg::ENTRY_COUNT_BITS-1:0] entry_count_ff;
   mcfh_pkg::color_entry_type             entries_ff [COLOR_ENTRIES];
   logic [COLOR_ENTRIES-1:0]              entry_hit_vec;

   function automatic logic [mcfh_pkg::CHAN_BITS-1:0] abs_diff(
      input logic [mcfh_pkg::CHAN_BITS-1:0] a,
      input logic [mcfh_pkg::CHAN_BITS-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // hit when the difference sum is within the limit, or every channel is within its shift
   function automatic logic entry_match(
      input mcfh_pkg::color_entry_type           e,
      input mcfh_pkg::req_payload_type           p,
      input logic [mcfh_pkg::DIFF_SUM_BITS-1:0]  limit
   );
      logic [mcfh_pkg::CHAN_BITS-1:0]     d_b;
      logic [mcfh_pkg::CHAN_BITS-1:0]     d_g;
      logic [mcfh_pkg::CHAN_BITS-1:0]     d_r;
      logic [mcfh_pkg::DIFF_SUM_BITS-1:0] sum;
      d_b = abs_diff(e.blue, p.blue);
      d_g = abs_diff(e.green, p.green);
      d_r = abs_diff(e.red, p.red);
      sum = {2'b00, d_b} + {2'b00, d_g} + {2'b00, d_r};
      return (sum <= limit) ||
             ((d_b <= e.blue_shift) && (d_g <= e.green_shift) && (d_r <= e.red_shift));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         max_diff_sum_ff <= '0;
         entry_count_ff  <= mcfh_pkg::ENTRY_COUNT_BITS'(1);
      end else if (csr_valid) begin
         if (csr_index == mcfh_pkg::CSR_MAX_DIFF_SUM) begin
            max_diff_sum_ff <= csr_data[mcfh_pkg::DIFF_SUM_BITS-1:0];
         end
         if (csr_index == mcfh_pkg::CSR_ENTRY_COUNT) begin
            entry_count_ff <= csr_data[mcfh_pkg::ENTRY_COUNT_BITS-1:0];
         end
      end
   end

   for (genvar i = 0; i < COLOR_ENTRIES; i++) begin : g_entry
      localparam logic [mcfh_pkg::CSR_INDEX_BITS-1:0] ENTRY_INDEX =
         mcfh_pkg::CSR_INDEX_BITS'(int'(mcfh_pkg::CSR_ENTRY0) + i);
      localparam logic [mcfh_pkg::ENTRY_COUNT_BITS-1:0] ENTRY_NUM =
         mcfh_pkg::ENTRY_COUNT_BITS'(i);

      always_ff @(posedge clock) begin
         if (reset) begin
            entries_ff[i] <= '0;
         end else if (csr_valid && (csr_index == ENTRY_INDEX)) begin
            entries_ff[i] <= csr_data;
         end
      end

      // an entry takes part only below the configured count
      assign entry_hit_vec[i] = (ENTRY_NUM < entry_count_ff) &&
                                entry_match(entries_ff[i], pixel, max_diff_sum_ff);
   end

   assign item.hit        = |entry_hit_vec;
   assign item.last_pixel = pixel.last_pixel;
   assign item.pixel_x    = pixel.pixel_x;
   assign item.pixel_y    = pixel.pixel_y;

endmodule

`default_nettype wire

/* sv/mcfh_queue.sv */
// Short queue of classified pixels between the front end and the hit tracker.
// Depends on mcfh_pkg.
`default_nettype none

module mcfh_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire mcfh_pkg::queue_item_type  push_item,
   input  wire logic                      pop,
   output mcfh_pkg::queue_item_type       head,
   output mcfh_pkg::queue_status_type     status
);

   mcfh_pkg::queue_item_type                slots_ff [mcfh_pkg::QUEUE_DEPTH];
   logic [mcfh_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [mcfh_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [mcfh_pkg::QUEUE_COUNT_BITS-1:0]   count_ff;
   logic [mcfh_pkg::QUEUE_COUNT_BITS-1:0]   count_in;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + mcfh_pkg::QUEUE_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - mcfh_pkg::QUEUE_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mcfh_pkg::QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mcfh_pkg::QUEUE_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head             = slots_ff[rd_ptr_ff];
   assign status.full      = (count_ff == mcfh_pkg::QUEUE_COUNT_BITS'(mcfh_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < mcfh_pkg::QUEUE_COUNT_BITS'(mcfh_pkg::QUEUE_DEPTH)))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");

endmodule

`default_nettype wire

/* sv/mcfh_back.sv */
// Back end: first-hit tracker of the current region and the result register.
// Depends on mcfh_pkg.
`default_nettype none

module mcfh_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_not_empty,
   input  wire mcfh_pkg::queue_item_type    head,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output mcfh_pkg::rsp_payload_type        rsp_payload
);

   logic                             hit_seen_ff;
   logic                             hit_seen_in;
   logic [mcfh_pkg::COORD_BITS-1:0]  first_x_ff;
   logic [mcfh_pkg::COORD_BITS-1:0]  first_x_in;
   logic [mcfh_pkg::COORD_BITS-1:0]  first_y_ff;
   logic [mcfh_pkg::COORD_BITS-1:0]  first_y_in;
   logic                             rsp_valid_ff;
   mcfh_pkg::rsp_payload_type        rsp_ff;
   logic                             out_free;

   // a region's last pixel needs the result register free; others always drain
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = q_not_empty && (!head.last_pixel || out_free);

   always_comb begin
      hit_seen_in = hit_seen_ff;
      first_x_in  = first_x_ff;
      first_y_in  = first_y_ff;
      if (head.hit && !hit_seen_ff) begin
         hit_seen_in = 1'b1;
         first_x_in  = head.pixel_x;
         first_y_in  = head.pixel_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff  <= 1'b0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop && head.last_pixel) begin
            hit_seen_ff <= 1'b0;
            first_x_ff  <= '0;
            first_y_ff  <= '0;
         end else if (pop) begin
            hit_seen_ff <= hit_seen_in;
            first_x_ff  <= first_x_in;
            first_y_ff  <= first_y_in;
         end
         if (pop && head.last_pixel) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last_pixel) begin
         rsp_ff.found <= hit_seen_in;
         rsp_ff.hit_x <= first_x_in;
         rsp_ff.hit_y <= first_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last_pixel) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_region_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.last_pixel) |=> (!hit_seen_ff && (first_x_ff == '0) && (first_y_ff == '0)))
      else $error("tracker not cleared after region end");

   a_miss_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> ((rsp_ff.hit_x == '0) && (rsp_ff.hit_y == '0)))
      else $error("miss result carries coordinates");

endmodule

`default_nettype wire

/* sv/multi_color_first_hit_finder_top.sv */
// Top level of the multi-color first-hit finder; instantiates mcfh_front, mcfh_queue
// and mcfh_back, all of which use mcfh_pkg.
`default_nettype none

// Pixels stream in one per clock, in the scan order the source picks, with last_pixel
// on the final pixel of the search region. Each pixel is matched against the enabled
// target entries (sum of channel differences at most max_diff_sum, or every channel
// within its entry's shift); the coordinates of the first matching pixel are kept and
// one result beat goes out after the region's last pixel, after which the tracker
// clears. Sustained rate is one pixel per cycle: the color match is combinational in
// front of a four-beat queue, and the tracker drains one queue entry per cycle. A
// result is registered when its last pixel is popped from the queue. req_stall rises only
// when the queue is full, which happens only while a result beat is held by rsp_stall
// and further pixels pile up behind the held region end. Configuration writes are always taken
// (csr_ready is tied high) and should be issued only while the block is idle. Nothing
// needs clearing after reset.
module multi_color_first_hit_finder_top #(
   parameter int COLOR_ENTRIES = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire mcfh_pkg::req_payload_type            req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output mcfh_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mcfh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mcfh_pkg::ENTRY_BITS-1:0]      csr_data
);

   mcfh_pkg::queue_item_type    front_item;
   mcfh_pkg::queue_item_type    queue_head;
   mcfh_pkg::queue_status_type  queue_status;
   logic                        push;
   logic                        pop;

   // hold the source only while the queue is full
   assign req_stall = queue_status.full;
   assign push      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   mcfh_front #(
      .COLOR_ENTRIES (COLOR_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pixel     (req_payload),
      .item      (front_item)
   );

   mcfh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head      (queue_head),
      .status    (queue_status)
   );

   // advance the tracker one beat per cycle; hold a region end until the result slot frees
   mcfh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (queue_status.not_empty),
      .head        (queue_head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* tb/mcfh_result_checker.sv */
// Result checker for the multi-color first-hit finder: watches the pixel, result and
// register channels, predicts each region's result and compares it. Uses mcfh_pkg.
module mcfh_result_checker #(
   parameter int COLOR_ENTRIES = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  mcfh_pkg::req_payload_type                req_payload,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  mcfh_pkg::rsp_payload_type                rsp_payload,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [mcfh_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [mcfh_pkg::ENTRY_BITS-1:0]          csr_data,
   output int                                       fail_count,
   output int                                       pending_count,
   output int                                       pixel_count,
   output int                                       result_count,
   output int                                       found_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the register file, updated on every register beat
   logic [mcfh_pkg::DIFF_SUM_BITS-1:0]    diff_limit;
   logic [mcfh_pkg::ENTRY_COUNT_BITS-1:0] entries_enabled;
   mcfh_pkg::color_entry_type             targets [COLOR_ENTRIES];

   // first-hit tracker of the region in progress
   logic                                  region_hit;
   logic [mcfh_pkg::COORD_BITS-1:0]       region_x;
   logic [mcfh_pkg::COORD_BITS-1:0]       region_y;

   mcfh_pkg::rsp_payload_type             region_result_q [$];

   // A target matches if the channel difference sum stays within the limit or every
   // channel stays within that target's own shift.
   function automatic logic pixel_hits_target(mcfh_pkg::color_entry_type t,
                                              mcfh_pkg::req_payload_type p);
      int d_red;
      int d_green;
      int d_blue;
      d_red   = int'(t.red) - int'(p.red);
      d_green = int'(t.green) - int'(p.green);
      d_blue  = int'(t.blue) - int'(p.blue);
      if (d_red < 0) d_red = -d_red;
      if (d_green < 0) d_green = -d_green;
      if (d_blue < 0) d_blue = -d_blue;
      return (d_red + d_green + d_blue <= int'(diff_limit)) ||
             (d_red <= int'(t.red_shift) && d_green <= int'(t.green_shift) &&
              d_blue <= int'(t.blue_shift));
   endfunction

   always @(posedge clock) begin : monitor
      mcfh_pkg::rsp_payload_type want;
      mcfh_pkg::rsp_payload_type got;
      logic                      hit;
      int                        n_enabled;
      if (reset) begin
         diff_limit      = '0;
         entries_enabled = mcfh_pkg::ENTRY_COUNT_BITS'(1);
         for (int k = 0; k < COLOR_ENTRIES; k++) targets[k] = '0;
         region_hit = 1'b0;
         region_x   = '0;
         region_y   = '0;
         region_result_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == mcfh_pkg::CSR_MAX_DIFF_SUM) begin
               diff_limit = csr_data[mcfh_pkg::DIFF_SUM_BITS-1:0];
            end else if (csr_index == mcfh_pkg::CSR_ENTRY_COUNT) begin
               entries_enabled = csr_data[mcfh_pkg::ENTRY_COUNT_BITS-1:0];
            end else if (csr_index >= mcfh_pkg::CSR_ENTRY0 &&
                         csr_index < mcfh_pkg::CSR_ENTRY0 + COLOR_ENTRIES) begin
               targets[csr_index - mcfh_pkg::CSR_ENTRY0] =
                  mcfh_pkg::color_entry_type'(csr_data);
            end
            // any other index is dropped by the block
         end

         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (region_result_q.size() == 0) begin
               $error("result beat with no region outstanding: found %0d hit_x %0d hit_y %0d",
                      got.found, got.hit_x, got.hit_y);
               fail_count++;
            end else begin
               want = region_result_q.pop_front();
               result_count++;
               if (want.found) found_count++;
               if (got.found !== want.found) begin
                  $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
                  fail_count++;
               end
               if (got.hit_x !== want.hit_x) begin
                  $error("hit_x mismatch: expected %0d, actual %0d", want.hit_x, got.hit_x);
                  fail_count++;
               end
               if (got.hit_y !== want.hit_y) begin
                  $error("hit_y mismatch: expected %0d, actual %0d", want.hit_y, got.hit_y);
                  fail_count++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            pixel_count++;
            n_enabled = (int'(entries_enabled) > COLOR_ENTRIES) ? COLOR_ENTRIES
                                                                 : int'(entries_enabled);
            hit = 1'b0;
            for (int k = 0; k < n_enabled; k++)
               if (pixel_hits_target(targets[k], req_payload)) hit = 1'b1;
            if (hit && !region_hit) begin
               region_hit = 1'b1;
               region_x   = req_payload.pixel_x;
               region_y   = req_payload.pixel_y;
            end
            if (req_payload.last_pixel) begin
               want.found = region_hit;
               want.hit_x = region_hit ? region_x : '0;
               want.hit_y = region_hit ? region_y : '0;
               region_result_q.push_back(want);
               region_hit = 1'b0;
               region_x   = '0;
               region_y   = '0;
            end
         end
      end
      pending_count <= region_result_q.size();
   end

endmodule

/* tb/multi_color_first_hit_finder_top_tb.sv */
// Testbench top for the multi-color first-hit finder: drives pixels, register writes and
// result stalls, and gives the verdict. Depends on mcfh_pkg and mcfh_result_checker.
module multi_color_first_hit_finder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLOR_ENTRIES  = 4;
   localparam int ITEM_TARGET    = 1850;
   localparam int RANDOM_PHASES  = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PRESSURE_HOLD  = 200;
   localparam int SETTLE_CYCLES  = 10;
   localparam int IDLE_HEAVY     = 83;
   localparam int IDLE_BOTH      = 29;
   localparam logic [mcfh_pkg::CSR_INDEX_BITS-1:0] CSR_FIRST_UNUSED =
      mcfh_pkg::CSR_INDEX_BITS'(int'(mcfh_pkg::CSR_ENTRY0) + COLOR_ENTRIES);

   logic                                 clock;
   logic                                 reset         = 1'b1;
   logic                                 req_valid     = 1'b0;
   logic                                 req_stall;
   mcfh_pkg::req_payload_type            req_payload   = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall     = 1'b0;
   mcfh_pkg::rsp_payload_type            rsp_payload;
   logic                                 csr_valid     = 1'b0;
   logic                                 csr_ready;
   logic [mcfh_pkg::CSR_INDEX_BITS-1:0]  csr_index     = '0;
   logic [mcfh_pkg::ENTRY_BITS-1:0]      csr_data      = '0;

   int fail_count;
   int pending_count;
   int pixel_count;
   int result_count;
   int found_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic rsp_hold     = 1'b0;
   int cycle_count    = 0;
   int held_off_cycles = 0;
   int settings_loaded = 0;
   int pixels_sent    = 0;

   // stimulus-side copy of the target table, used only to aim pixels near the targets
   mcfh_pkg::color_entry_type color_table [COLOR_ENTRIES];

   multi_color_first_hit_finder_top #(
      .COLOR_ENTRIES(COLOR_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   mcfh_result_checker #(
      .COLOR_ENTRIES(COLOR_ENTRIES)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .pixel_count   (pixel_count),
      .result_count  (result_count),
      .found_count   (found_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: stall at random, or hold off completely while the pressure stretch runs.
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);
   end

   // Count cycles in which the block pushes back on an offered pixel.
   always @(posedge clock) begin
      if (req_valid && req_stall) held_off_cycles <= held_off_cycles + 1;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, pending_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic mcfh_pkg::req_payload_type pixel(int x, int y, int r, int g, int b,
                                                       bit last);
      mcfh_pkg::req_payload_type p;
      p.pixel_x    = mcfh_pkg::COORD_BITS'(x);
      p.pixel_y    = mcfh_pkg::COORD_BITS'(y);
      p.red        = mcfh_pkg::CHAN_BITS'(r);
      p.green      = mcfh_pkg::CHAN_BITS'(g);
      p.blue       = mcfh_pkg::CHAN_BITS'(b);
      p.last_pixel = last;
      return p;
   endfunction

   function automatic logic [mcfh_pkg::ENTRY_BITS-1:0] target(int r, int g, int b,
                                                              int rs, int gs, int bs);
      mcfh_pkg::color_entry_type e;
      e.red         = mcfh_pkg::CHAN_BITS'(r);
      e.green       = mcfh_pkg::CHAN_BITS'(g);
      e.blue        = mcfh_pkg::CHAN_BITS'(b);
      e.red_shift   = mcfh_pkg::CHAN_BITS'(rs);
      e.green_shift = mcfh_pkg::CHAN_BITS'(gs);
      e.blue_shift  = mcfh_pkg::CHAN_BITS'(bs);
      return e;
   endfunction

   // Nudge a channel a little off its target, clamped to the channel range.
   function automatic logic [mcfh_pkg::CHAN_BITS-1:0] jitter(
      logic [mcfh_pkg::CHAN_BITS-1:0] c
   );
      int v;
      v = int'(c) + int'($urandom_range(24)) - 12;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return mcfh_pkg::CHAN_BITS'(v);
   endfunction

   // Offer one pixel beat after a random gap; hold it until the block takes it.
   task automatic send_pixel(input mcfh_pkg::req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // One register beat, then valid low again before returning, so the valid never toggles within a step.
   task automatic write_csr(input logic [mcfh_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mcfh_pkg::ENTRY_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx >= mcfh_pkg::CSR_ENTRY0 && idx < CSR_FIRST_UNUSED)
         color_table[idx - mcfh_pkg::CSR_ENTRY0] = mcfh_pkg::color_entry_type'(data);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One search region: mostly a scan-order run, now and then scattered coordinates.
   // About half the pixels are aimed close to one of the targets so hits are common.
   task automatic send_region(input int len);
      mcfh_pkg::req_payload_type p;
      mcfh_pkg::color_entry_type e;
      int x0;
      int y0;
      bit scattered;
      x0 = $urandom_range(4095);
      y0 = $urandom_range(4095);
      scattered = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
         p = pixel(scattered ? $urandom_range(4095) : x0 + i,
                   scattered ? $urandom_range(4095) : y0,
                   $urandom_range(255), $urandom_range(255), $urandom_range(255),
                   i == len - 1);
         if ($urandom_range(99) < 45) begin
            e = color_table[$urandom_range(COLOR_ENTRIES - 1)];
            p.red   = jitter(e.red);
            p.green = jitter(e.green);
            p.blue  = jitter(e.blue);
         end
         send_pixel(p);
      end
   endtask

   function automatic int region_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $urandom_range(1, 6);
      if (pick < 90) return $urandom_range(7, 16);
      return $urandom_range(17, 40);
   endfunction

   // Load a fresh random setting into every register; upper data bits carry noise.
   task automatic load_random_settings();
      logic [mcfh_pkg::ENTRY_BITS-1:0] word;
      mcfh_pkg::color_entry_type       e;
      int                              pick;
      pick = $urandom_range(9);
      word = mcfh_pkg::ENTRY_BITS'({$urandom, $urandom});
      case (pick)
         0:       word[mcfh_pkg::DIFF_SUM_BITS-1:0] = '0;
         1:       word[mcfh_pkg::DIFF_SUM_BITS-1:0] = mcfh_pkg::DIFF_SUM_BITS'(765);
         2:       word[mcfh_pkg::DIFF_SUM_BITS-1:0] = '1;
         3, 4, 5, 6: word[mcfh_pkg::DIFF_SUM_BITS-1:0] =
            mcfh_pkg::DIFF_SUM_BITS'($urandom_range(60));
         default: word[mcfh_pkg::DIFF_SUM_BITS-1:0] =
            mcfh_pkg::DIFF_SUM_BITS'($urandom_range(1023));
      endcase
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, word);
      word = mcfh_pkg::ENTRY_BITS'({$urandom, $urandom});
      word[mcfh_pkg::ENTRY_COUNT_BITS-1:0] = ($urandom_range(9) < 8)
         ? mcfh_pkg::ENTRY_COUNT_BITS'($urandom_range(1, COLOR_ENTRIES))
         : mcfh_pkg::ENTRY_COUNT_BITS'($urandom_range(7));
      write_csr(mcfh_pkg::CSR_ENTRY_COUNT, word);
      for (int k = 0; k < COLOR_ENTRIES; k++) begin
         e = mcfh_pkg::color_entry_type'(mcfh_pkg::ENTRY_BITS'({$urandom, $urandom}));
         // keep most shifts small so the per-channel test both hits and misses
         if ($urandom_range(9) < 7) begin
            e.red_shift   = mcfh_pkg::CHAN_BITS'($urandom_range(24));
            e.green_shift = mcfh_pkg::CHAN_BITS'($urandom_range(24));
            e.blue_shift  = mcfh_pkg::CHAN_BITS'($urandom_range(24));
         end
         write_csr(mcfh_pkg::CSR_INDEX_BITS'(int'(mcfh_pkg::CSR_ENTRY0) + k), e);
      end
      if ($urandom_range(3) == 0)
         write_csr(mcfh_pkg::CSR_INDEX_BITS'($urandom_range(int'(CSR_FIRST_UNUSED), 7)),
                   mcfh_pkg::ENTRY_BITS'({$urandom, $urandom}));
      settings_loaded++;
   endtask

   initial begin
      int per_phase;
      int phase_start;
      for (int k = 0; k < COLOR_ENTRIES; k++) color_table[k] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, no idling ----
      // exact match only: single target, zero limit, zero shifts
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, '0);
      write_csr(mcfh_pkg::CSR_ENTRY_COUNT, mcfh_pkg::ENTRY_BITS'(1));
      write_csr(mcfh_pkg::CSR_ENTRY0, target(30, 20, 10, 0, 0, 0));
      settings_loaded++;
      send_pixel(pixel(4095, 4095, 30, 20, 10, 1));   // hit on the region's last pixel
      send_pixel(pixel(0, 0, 255, 255, 255, 1));      // region with no hit
      send_pixel(pixel(5, 6, 0, 0, 0, 0));
      send_pixel(pixel(1, 2, 30, 20, 10, 0));         // first hit
      send_pixel(pixel(3, 4, 30, 20, 10, 0));         // later hit, ignored
      send_pixel(pixel(0, 4095, 30, 21, 10, 1));
      wait_idle();

      // difference sum right at and just past the limit, then per-channel shifts
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, mcfh_pkg::ENTRY_BITS'(2));
      send_pixel(pixel(2730, 1365, 31, 21, 10, 1));
      send_pixel(pixel(1365, 2730, 31, 21, 11, 1));
      wait_idle();
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, '0);
      write_csr(mcfh_pkg::CSR_ENTRY0, target(100, 100, 100, 5, 5, 5));
      settings_loaded++;
      send_pixel(pixel(2048, 1, 105, 95, 100, 1));
      send_pixel(pixel(1, 2048, 106, 100, 100, 1));
      wait_idle();

      // no entry enabled: nothing hits, even with the widest limit
      write_csr(mcfh_pkg::CSR_ENTRY_COUNT, '0);
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, mcfh_pkg::ENTRY_BITS'(1023));
      settings_loaded++;
      send_pixel(pixel(7, 7, 0, 0, 0, 1));
      wait_idle();

      // count above the table size saturates: only the last entry can match here
      write_csr(mcfh_pkg::CSR_ENTRY_COUNT, mcfh_pkg::ENTRY_BITS'(7));
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, '0);
      write_csr(mcfh_pkg::CSR_INDEX_BITS'(int'(mcfh_pkg::CSR_ENTRY0) + 3),
                target(255, 255, 255, 0, 0, 0));
      settings_loaded++;
      send_pixel(pixel(4095, 0, 255, 255, 255, 1));
      wait_idle();

      // limit above the largest possible sum, at it, and one below it
      write_csr(mcfh_pkg::CSR_ENTRY_COUNT, mcfh_pkg::ENTRY_BITS'(1));
      write_csr(mcfh_pkg::CSR_ENTRY0, target(0, 0, 0, 0, 0, 0));
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, mcfh_pkg::ENTRY_BITS'(1023));
      send_pixel(pixel(2730, 1365, 255, 255, 255, 1));
      wait_idle();
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, mcfh_pkg::ENTRY_BITS'(765));
      send_pixel(pixel(2730, 1365, 255, 255, 255, 1));
      wait_idle();
      write_csr(mcfh_pkg::CSR_MAX_DIFF_SUM, mcfh_pkg::ENTRY_BITS'(764));
      send_pixel(pixel(2730, 1365, 255, 255, 255, 1));
      wait_idle();

      // writes past the register list must leave every setting alone
      write_csr(CSR_FIRST_UNUSED, '1);
      write_csr(mcfh_pkg::CSR_INDEX_BITS'(7), '1);
      settings_loaded++;
      send_pixel(pixel(1, 1, 0, 0, 0, 1));
      send_pixel(pixel(2, 2, 255, 255, 255, 1));
      wait_idle();

      // ---- pressure: hold the result side off while short regions keep coming ----
      load_random_settings();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (PRESSURE_HOLD) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            repeat (40) send_region($urandom_range(1, 2));
         end
      join
      wait_idle();

      // ---- random part: one idling style per phase, new settings each phase ----
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_random_settings();
         case (phase % 4)
            0: begin send_idle_pct = 0;          recv_stall_pct <= 0;          end
            1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct <= 0;          end
            2: begin send_idle_pct = 0;          recv_stall_pct <= IDLE_HEAVY; end
            default: begin
               send_idle_pct  = IDLE_BOTH;
               recv_stall_pct <= IDLE_BOTH;
            end
         endcase
         per_phase   = (ITEM_TARGET - pixels_sent) / (RANDOM_PHASES - phase);
         phase_start = pixels_sent;
         while (pixels_sent - phase_start < per_phase) send_region(region_length());
         wait_idle();
      end

      $display("Covered %0d pixels in %0d regions, %0d of them with a hit, over %0d settings.",
               pixel_count, result_count, found_count, settings_loaded);
      $display("Input was held off for %0d cycles while results backed up.", held_off_cycles);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
